/* rtl/core/ecv_pkg.sv */
// shared types, widths and constants for the epoch seconds to civil time block
// no dependencies; imported by every module under rtl/core
package ecv_pkg;

  localparam int SECS_W   = 39;
  localparam int WDAY_W   = 23;
  localparam int TOD_W    = 17;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // split of seconds into days: 86400 = 128 * 675
  localparam logic [32:0] SPLIT_BIAS = 33'd2147511825;  // 675 * 3181499
  localparam logic [23:0] RECIP_675  = 24'd12725829;    // floor(2^33 / 675)
  localparam int          RECIP_675_SH = 33;
  // day count biased by 719468 and by 17 eras, minus the split bias quotient
  localparam logic [22:0] WDAY_BIAS  = 23'd21618;
  localparam logic [15:0] ERA_OFFSET = 16'd6800;        // 17 eras of 400 years

  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [5:0]  RECIP_ERA    = 6'd57;         // floor(2^23 / 146097)
  localparam logic [7:0]  RECIP_1460   = 8'd179;        // floor(2^18 / 1460)
  localparam logic [2:0]  RECIP_36524  = 3'd7;          // floor(2^18 / 36524)
  localparam logic [9:0]  RECIP_365    = 10'd718;       // floor(2^18 / 365)
  localparam logic [5:0]  RECIP_3600   = 6'd36;         // floor(2^17 / 3600)
  localparam logic [6:0]  RECIP_60     = 7'd68;         // floor(2^12 / 60)
  localparam logic [15:0] YEAR_MAX     = 16'd9999;

  localparam int DATE_STAGES = 9;
  localparam int TOD_STAGES  = 4;
  localparam int TOD_PAD     = DATE_STAGES - TOD_STAGES;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               out_of_range;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } tod_t;

  typedef struct packed {
    date_t date;
    tod_t  tod;
  } result_t;

  // first day of each month in a march-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/ecv_split.sv */
// three stage floor split of signed seconds into a biased day count and second of day
// depends on ecv_pkg
module ecv_split (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [ecv_pkg::SECS_W-1:0]   secs,
  output logic                         out_valid,
  output logic [ecv_pkg::WDAY_W-1:0]   wday,
  output logic [ecv_pkg::TOD_W-1:0]    tod
);
  import ecv_pkg::*;

  logic [2:0]  v_r;
  logic [32:0] u1_r, u2_r;
  logic [6:0]  lo1_r, lo2_r;
  logic [23:0] q2_r;
  logic [WDAY_W-1:0] wday_r;
  logic [TOD_W-1:0]  tod_r;

  logic [32:0] u_nxt;
  logic [56:0] prod;
  logic [33:0] qm;
  logic [32:0] rfull;
  logic [10:0] rem;
  logic [23:0] q_fix;
  logic [9:0]  r_fix;

  // floor(t / 128) is an arithmetic shift, bias keeps the rest unsigned
  assign u_nxt = {secs[SECS_W-1], secs[SECS_W-1:7]} + SPLIT_BIAS;
  assign prod  = 57'(u1_r) * 57'(RECIP_675);
  assign qm    = 34'(q2_r) * 34'd675;
  assign rfull = u2_r - qm[32:0];
  assign rem   = rfull[10:0];

  always_comb begin
    if (rem >= 11'd675) begin
      q_fix = q2_r + 24'd1;
      r_fix = 10'(rem - 11'd675);
    end else begin
      q_fix = q2_r;
      r_fix = rem[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r   <= u_nxt;
      lo1_r  <= secs[6:0];
      u2_r   <= u1_r;
      lo2_r  <= lo1_r;
      q2_r   <= prod[56:RECIP_675_SH];
      wday_r <= q_fix[WDAY_W-1:0] + WDAY_BIAS;
      tod_r  <= {r_fix, lo2_r};
    end
  end

  assign out_valid = v_r[2];
  assign wday      = wday_r;
  assign tod       = tod_r;

endmodule

/* rtl/core/ecv_date.sv */
// nine stage civil-from-days pipeline: era, day of era, year of era, month and day
// depends on ecv_pkg
module ecv_date (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ecv_pkg::WDAY_W-1:0] wday,
  output logic                       out_valid,
  output ecv_pkg::date_t             date
);
  import ecv_pkg::*;

  logic [DATE_STAGES-1:0] v_r;

  // stage 1: era estimate
  logic [WDAY_W-1:0] w1_r;
  logic [5:0]        e1_r;
  logic [28:0]       ep;
  // stage 2: era and day of era
  logic [5:0]  era2_r;
  logic [17:0] doe2_r;
  logic [23:0] em;
  logic [23:0] er;
  // stage 3: century and leap estimates
  logic [5:0]  era3_r;
  logic [17:0] doe3_r;
  logic [6:0]  a3_r;
  logic [2:0]  b3_r;
  logic [25:0] ap;
  logic [20:0] bp;
  // stage 4: leap corrected day count
  logic [5:0]  era4_r;
  logic [17:0] doe4_r, n4_r;
  logic [17:0] arem, brem;
  logic [17:0] a_fix, b_fix, c_fix;
  // stage 5: year of era estimate
  logic [5:0]  era5_r;
  logic [17:0] doe5_r, n5_r;
  logic [8:0]  y5_r;
  logic [27:0] yp;
  // stage 6: year of era
  logic [5:0]  era6_r;
  logic [17:0] doe6_r;
  logic [8:0]  yoe6_r;
  logic [17:0] yr;
  // stage 7: day of year
  logic [5:0]  era7_r;
  logic [8:0]  yoe7_r, doy7_r;
  logic [1:0]  cent;
  logic [17:0] ysub;
  logic [17:0] doy_full;
  // stage 8: march-based month
  logic [5:0]  era8_r;
  logic [8:0]  yoe8_r, doy8_r;
  logic [3:0]  mp8_r;
  logic [3:0]  mp_cnt;
  // stage 9: calendar fields
  date_t       date_r;
  logic [8:0]  dsub;
  logic [3:0]  m_nxt;
  logic        leap;
  logic [15:0] y_nxt;
  logic        oor;

  // era estimate is taken from the incoming day count so it lines up with w1_r
  assign ep = 29'(wday) * 29'(RECIP_ERA);
  assign em = 24'(e1_r) * 24'(DAYS_PER_ERA);
  assign er = 24'(w1_r) - em;

  assign ap = 26'(doe2_r) * 26'(RECIP_1460);
  assign bp = 21'(doe2_r) * 21'(RECIP_36524);

  assign arem  = doe3_r - 18'(a3_r * 18'd1460);
  assign brem  = doe3_r - 18'(b3_r * 18'd36524);
  assign a_fix = 18'(a3_r) + ((arem >= 18'd1460) ? 18'd1 : 18'd0);
  assign b_fix = 18'(b3_r) + ((brem >= 18'd36524) ? 18'd1 : 18'd0);
  assign c_fix = (doe3_r == 18'd146096) ? 18'd1 : 18'd0;

  assign yp = 28'(n4_r) * 28'(RECIP_365);
  assign yr = n5_r - 18'(y5_r * 18'd365);

  always_comb begin
    if (yoe6_r >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe6_r >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe6_r >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
  end
  assign ysub     = 18'(yoe6_r * 18'd365) + 18'(yoe6_r[8:2]) - 18'(cent);
  assign doy_full = doe6_r - ysub;

  // month index counts the month starts already passed
  always_comb begin
    mp_cnt = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy7_r >= month_start(4'(k))) begin
        mp_cnt = mp_cnt + 4'd1;
      end
    end
  end

  assign dsub  = doy8_r - month_start(mp8_r) + 9'd1;
  assign leap  = (mp8_r >= 4'd10);
  assign m_nxt = leap ? mp8_r - 4'd9 : mp8_r + 4'd3;
  assign y_nxt = 16'(yoe8_r) + 16'(era8_r * 15'd400) + 16'(leap) - ERA_OFFSET;
  assign oor   = y_nxt[15] || (y_nxt > YEAR_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DATE_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r   <= wday;
      e1_r   <= ep[28:23];
      if (er >= 24'(DAYS_PER_ERA)) begin
        era2_r <= e1_r + 6'd1;
        doe2_r <= 18'(er - 24'(DAYS_PER_ERA));
      end else begin
        era2_r <= e1_r;
        doe2_r <= er[17:0];
      end
      era3_r <= era2_r;
      doe3_r <= doe2_r;
      a3_r   <= ap[24:18];
      b3_r   <= bp[20:18];
      era4_r <= era3_r;
      doe4_r <= doe3_r;
      n4_r   <= doe3_r - a_fix + b_fix - c_fix;
      era5_r <= era4_r;
      doe5_r <= doe4_r;
      n5_r   <= n4_r;
      y5_r   <= yp[26:18];
      era6_r <= era5_r;
      doe6_r <= doe5_r;
      yoe6_r <= (yr >= 18'd365) ? y5_r + 9'd1 : y5_r;
      era7_r <= era6_r;
      yoe7_r <= yoe6_r;
      doy7_r <= doy_full[8:0];
      era8_r <= era7_r;
      yoe8_r <= yoe7_r;
      doy8_r <= doy7_r;
      mp8_r  <= mp_cnt;
      if (oor) begin
        date_r <= '{year: '0, month: '0, day: '0, out_of_range: 1'b1};
      end else begin
        date_r <= '{year: y_nxt[YEAR_W-1:0], month: m_nxt, day: dsub[DAY_W-1:0],
                    out_of_range: 1'b0};
      end
    end
  end

  assign out_valid = v_r[DATE_STAGES-1];
  assign date      = date_r;

endmodule

/* rtl/core/ecv_tod.sv */
// second of day to hour, minute and second, padded to the date pipeline depth
// depends on ecv_pkg
module ecv_tod (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ecv_pkg::TOD_W-1:0] tod,
  output ecv_pkg::tod_t             hms
);
  import ecv_pkg::*;

  logic [TOD_W-1:0]  tod1_r;
  logic [4:0]        h1_r, h2_r, h3_r;
  logic [11:0]       rem2_r, rem3_r;
  logic [5:0]        m3_r;
  tod_t              calc_r;
  tod_t              pad_r [TOD_PAD];

  logic [22:0] hp;
  logic [16:0] hr;
  logic [18:0] mp;
  logic [11:0] sr;

  assign hp = 23'(tod) * 23'(RECIP_3600);
  assign hr = tod1_r - 17'(h1_r * 17'd3600);
  assign mp = 19'(rem2_r) * 19'(RECIP_60);
  assign sr = rem3_r - 12'(m3_r * 12'd60);

  always_ff @(posedge clk) begin
    if (en) begin
      tod1_r <= tod;
      h1_r   <= hp[21:17];
      if (hr >= 17'd3600) begin
        h2_r   <= h1_r + 5'd1;
        rem2_r <= 12'(hr - 17'd3600);
      end else begin
        h2_r   <= h1_r;
        rem2_r <= hr[11:0];
      end
      h3_r   <= h2_r;
      rem3_r <= rem2_r;
      m3_r   <= mp[17:12];
      if (sr >= 12'd60) begin
        calc_r <= '{hour: h3_r, minute: m3_r + 6'd1, second: 6'(sr - 12'd60)};
      end else begin
        calc_r <= '{hour: h3_r, minute: m3_r, second: sr[5:0]};
      end
      pad_r[0] <= calc_r;
      for (int k = 1; k < TOD_PAD; k++) begin
        pad_r[k] <= pad_r[k-1];
      end
    end
  end

  assign hms = pad_r[TOD_PAD-1];

endmodule

/* rtl/core/ecv_skid.sv */
// output register with one skid entry, so the pipeline keeps moving while a result waits
// depends on ecv_pkg
module ecv_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  ecv_pkg::result_t     in_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ecv_pkg::result_t     out_data
);
  import ecv_pkg::*;

  logic    out_v_r, skid_v_r;
  result_t out_d_r, skid_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!skid_v_r) begin
      if (!out_v_r || out_ready) begin
        out_v_r <= in_valid;
      end else if (in_valid) begin
        skid_v_r <= 1'b1;
      end
    end else if (out_ready) begin
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      if (!out_v_r || out_ready) begin
        out_d_r <= in_data;
      end else begin
        skid_d_r <= in_data;
      end
    end else if (out_ready) begin
      out_d_r <= skid_d_r;
    end
  end

  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

/* rtl/core/epoch_seconds_to_civil_time.sv */
// top level of the epoch seconds to civil time converter
// depends on ecv_pkg, ecv_split, ecv_date, ecv_tod and ecv_skid
//
// usage
// - in_* takes one request per cycle while in_tready is high: a signed 39-bit count
//   of seconds since 1970-01-01 00:00:00 utc in in_tdata[38:0]
// - out_* gives one result per request, in order: year, month, day, hour,
//   minute and second in out_tdata, the out-of-range flag in out_tuser
// - years below 0 or above 9999 raise the flag and zero year, month and day;
//   the time of day is still given
// - the path has 13 register stages: three split off the day count, nine form
//   the date path, one is the output register
// - one request per cycle enters while the skid entry is free; some stages hold
//   a constant multiplier together with a subtract and compare
// - when the receiver stalls the pending result is held and one more lands in
//   the skid entry; only then does the whole pipeline freeze and in_tready drop
// - in_tready depends on registered state only
// - synchronous active-low reset clears all valid bits, nothing else is kept
module epoch_seconds_to_civil_time (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [38:0] epoch_seconds, [39] pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [13:0] year, [17:14] month, [22:18] day,
                                  // [27:23] hour, [33:28] minute, [39:34] second
  output logic [0:0]  out_tuser   // [0] out_of_range
);
  import ecv_pkg::*;

  logic              en;
  logic              skid_full;
  logic              split_valid;
  logic [WDAY_W-1:0] wday;
  logic [TOD_W-1:0]  tod;
  logic              date_valid;
  date_t             date;
  tod_t              hms;
  result_t           res;
  result_t           out_res;

  // the pipeline advances whenever the skid entry is free
  assign en        = !skid_full;
  assign in_tready = en;

  ecv_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .secs      (in_tdata[SECS_W-1:0]),
    .out_valid (split_valid),
    .wday      (wday),
    .tod       (tod)
  );

  ecv_date u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (split_valid),
    .wday      (wday),
    .out_valid (date_valid),
    .date      (date)
  );

  // time of day runs beside the date path with the same depth
  ecv_tod u_tod (
    .clk (clk),
    .en  (en),
    .tod (tod),
    .hms (hms)
  );

  assign res = '{date: date, tod: hms};

  ecv_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (date_valid),
    .in_data   (res),
    .full      (skid_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {out_res.tod.second, out_res.tod.minute, out_res.tod.hour,
                      out_res.date.day, out_res.date.month, out_res.date.year};
  assign out_tuser = out_res.date.out_of_range;

`ifndef NO_ASSERTIONS
  // a filled skid entry always sits behind a pending result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full |-> out_tvalid)
    else $error("skid entry filled without a pending result");

  // a flagged result carries no date
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res.date.out_of_range) |->
      (out_res.date.year == '0 && out_res.date.month == '0 && out_res.date.day == '0))
    else $error("out-of-range result with nonzero date");

  // an in-range result has a month of 1 to 12, a nonzero day and a year of at most 9999
  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_res.date.out_of_range) |->
      (out_res.date.month >= 4'd1 && out_res.date.month <= 4'd12 &&
       out_res.date.day >= 5'd1 && out_res.date.year <= 14'd9999))
    else $error("illegal calendar date");

  // time of day stays in range
  a_tod_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res.tod.hour <= 5'd23 && out_res.tod.minute <= 6'd59 &&
                    out_res.tod.second <= 6'd59))
    else $error("illegal time of day");
`endif

endmodule
